// ===== sv/nhlm_pkg.sv =====
// ----------------------------------------------------------------------------
// nhlm_pkg
// shared types, constants and helpers for the nibble handshake link master
// ----------------------------------------------------------------------------
package nhlm_pkg;

  localparam int unsigned SpinW      = 14;
  localparam logic [SpinW-1:0] SpinReset = 14'd10000;

  localparam logic [7:0] PeerFlag = 8'h08;
  localparam logic [3:0] PeerInv  = 4'h8;    // bit 7 of the status, seen in the nibble
  localparam logic [4:0] DrvFlag  = 5'h10;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WSET   = 3'd1,
    PH_WCLR   = 3'd2,
    PH_WRCLR  = 3'd3,
    PH_WRNEXT = 3'd4,
    PH_FASTLO = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    MODE_EXCHANGE = 2'd0,
    MODE_WRITE    = 2'd1,
    MODE_FAST     = 2'd2,
    MODE_RSVD     = 2'd3
  } xfer_mode_e;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_e;

  typedef struct packed {
    phase_e           phase;
    logic             nibble_sel;
    logic [SpinW-1:0] poll_count;
    logic [7:0]       shift_byte;
    logic [7:0]       recv_acc;
    logic             stuck_seen;
    logic [4:0]       drive_reg;
  } link_state_t;

  // nibble to send: high nibble while sel is clear
  function automatic logic [3:0] cur_nibble(input logic sel, input logic [7:0] byte_v);
    cur_nibble = sel ? byte_v[3:0] : byte_v[7:4];
  endfunction

endpackage

// ===== sv/nhlm_core.sv =====
// ----------------------------------------------------------------------------
// nhlm_core
// next-state and result logic of the handshake for one beat
// ----------------------------------------------------------------------------
module nhlm_core (
  input  nhlm_pkg::link_state_t      state_i,
  input  logic                       op_i,
  input  logic [7:0]                 tx_byte_i,
  input  logic [1:0]                 xfer_mode_i,
  input  logic [7:0]                 status_sample_i,
  input  logic [nhlm_pkg::SpinW-1:0] spin_limit_i,
  output nhlm_pkg::link_state_t      state_o,
  output logic                       done_o
);
  import nhlm_pkg::*;

  logic             peer_flag;
  logic             give_up;
  logic [SpinW-1:0] poll_inc;
  logic [3:0]       peer_nib;
  xfer_mode_e       mode;

  assign peer_flag = (status_sample_i & PeerFlag) != 8'h00;
  assign give_up   = state_i.poll_count >= spin_limit_i;
  assign poll_inc  = state_i.poll_count + SpinW'(1);
  assign peer_nib  = peer_flag ? (status_sample_i[7:4] ^ PeerInv) : 4'h0;
  assign mode      = xfer_mode_e'(xfer_mode_i);

  always_comb begin
    state_o = state_i;
    done_o  = 1'b0;
    if (op_e'(op_i) == OP_START) begin
      if (state_i.phase == PH_IDLE && mode != MODE_RSVD) begin
        state_o.shift_byte = tx_byte_i;
        state_o.nibble_sel = 1'b0;
        state_o.poll_count = '0;
        state_o.recv_acc   = 8'h00;
        state_o.stuck_seen = 1'b0;
        state_o.drive_reg  = DrvFlag | {1'b0, cur_nibble(1'b0, tx_byte_i)};
        unique case (mode)
          MODE_EXCHANGE: state_o.phase = PH_WSET;
          MODE_WRITE:    state_o.phase = PH_WRCLR;
          default:       state_o.phase = PH_FASTLO;
        endcase
      end
    end else begin
      unique case (state_i.phase)
        PH_IDLE: begin
        end
        PH_WSET: begin
          if (peer_flag || give_up) begin
            if (!peer_flag) begin
              state_o.stuck_seen = 1'b1;
            end
            if (state_i.nibble_sel) begin
              state_o.recv_acc = {state_i.recv_acc[7:4], peer_nib};
            end else begin
              state_o.recv_acc = {peer_nib, 4'h0};
            end
            state_o.drive_reg  = 5'h00;
            state_o.poll_count = '0;
            state_o.phase      = PH_WCLR;
          end else begin
            state_o.poll_count = poll_inc;
          end
        end
        PH_WCLR: begin
          if (!peer_flag || give_up) begin
            if (peer_flag) begin
              state_o.stuck_seen = 1'b1;
            end
            state_o.poll_count = '0;
            if (!state_i.nibble_sel) begin
              state_o.nibble_sel = 1'b1;
              state_o.drive_reg  = DrvFlag | {1'b0, cur_nibble(1'b1, state_i.shift_byte)};
              state_o.phase      = PH_WSET;
            end else begin
              state_o.phase = PH_IDLE;
              done_o        = 1'b1;
            end
          end else begin
            state_o.poll_count = poll_inc;
          end
        end
        PH_WRCLR: begin
          state_o.drive_reg = 5'h00;
          if (!state_i.nibble_sel) begin
            state_o.nibble_sel = 1'b1;
            state_o.phase      = PH_WRNEXT;
          end else begin
            state_o.phase = PH_IDLE;
            done_o        = 1'b1;
          end
        end
        PH_WRNEXT: begin
          state_o.drive_reg =
            DrvFlag | {1'b0, cur_nibble(state_i.nibble_sel, state_i.shift_byte)};
          state_o.phase     = PH_WRCLR;
        end
        PH_FASTLO: begin
          state_o.nibble_sel = 1'b1;
          state_o.drive_reg  = {1'b0, cur_nibble(1'b1, state_i.shift_byte)};
          state_o.phase      = PH_IDLE;
          done_o             = 1'b1;
        end
        default: begin
          state_o.phase = PH_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/nibble_handshake_link_master.sv =====
// ----------------------------------------------------------------------------
// nibble_handshake_link_master
// host side of a four-phase nibble handshake on a parallel byte link
// ----------------------------------------------------------------------------
// usage
//   slave side beats carry either a start (tuser = 1: byte and mode) or a
//   tick (tuser = 0) carrying one sample of the port status lines
//   every accepted beat gives exactly one master side beat: the pin value
//   to drive, the byte received so far, timeout and busy flags; tlast marks
//   the beat that finishes a byte transfer
//   cfg_we_i writes spin_limit, the number of failing polls allowed per wait
// timing
//   two register stages (input register, result register): a beat taken into
//   the input register is offered on the master side once it moves on into the
//   result register, and one beat per cycle is taken while the receiver keeps up
//   the handshake state moves forward once per beat, in the beat's second
//   stage, so back-to-back ticks each see the state left by the one before
// reset
//   rst_ni clears both stages and the handshake state; spin_limit returns to
//   10000
// stall
//   when m_axis_tready_i is low the result register holds, the input
//   register fills, and s_axis_tready_o drops; no beat is lost
// ----------------------------------------------------------------------------
module nibble_handshake_link_master (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [nhlm_pkg::SpinW-1:0] cfg_wdata_i,       // spin_limit
  // slave side
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [23:0]                s_axis_tdata_i,    // tx_byte, xfer_mode, status_sample, pad
  input  logic                       s_axis_tuser_i,    // op
  // master side
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [15:0]                m_axis_tdata_o,    // drive, rx_byte, timed_out, busy_res, pad
  output logic                       m_axis_tlast_o     // done_res
);
  import nhlm_pkg::*;

  logic [SpinW-1:0] spin_limit_q;

  // input register
  logic       in_valid_q;
  logic       in_op_q;
  logic [7:0] in_tx_byte_q;
  logic [1:0] in_mode_q;
  logic [7:0] in_status_q;

  // handshake state
  link_state_t state_q, state_d;
  logic        done_d;

  // result register
  logic       out_valid_q;
  logic [4:0] out_drive_q;
  logic [7:0] out_rx_byte_q;
  logic       out_done_q;
  logic       out_timeout_q;
  logic       out_busy_q;

  logic s_acc;
  logic stage_adv;   // input register moves into the result register

  assign stage_adv       = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || stage_adv;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spin_limit_q <= SpinReset;
    end else if (cfg_we_i) begin
      spin_limit_q <= cfg_wdata_i;
    end
  end

  // stage one: capture the beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_op_q      <= s_axis_tuser_i;
      in_tx_byte_q <= s_axis_tdata_i[7:0];
      in_mode_q    <= s_axis_tdata_i[9:8];
      in_status_q  <= s_axis_tdata_i[17:10];
    end
  end

  nhlm_core u_core (
    .state_i         (state_q),
    .op_i            (in_op_q),
    .tx_byte_i       (in_tx_byte_q),
    .xfer_mode_i     (in_mode_q),
    .status_sample_i (in_status_q),
    .spin_limit_i    (spin_limit_q),
    .state_o         (state_d),
    .done_o          (done_d)
  );

  // stage two: handshake state and result, updated together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, nibble_sel: 1'b0, poll_count: '0, shift_byte: 8'h00,
                   recv_acc: 8'h00, stuck_seen: 1'b0, drive_reg: 5'h00};
    end else if (stage_adv) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_adv) begin
      out_drive_q   <= state_d.drive_reg;
      out_rx_byte_q <= state_d.recv_acc;
      out_done_q    <= done_d;
      out_timeout_q <= state_d.stuck_seen;
      out_busy_q    <= state_d.phase != PH_IDLE;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_busy_q, out_timeout_q, out_rx_byte_q, out_drive_q};
  assign m_axis_tlast_o  = out_done_q;

endmodule
